FILE: src/plu_pkg.sv
// package: constants, register indexes, pipeline record type and fixed-point helpers
`timescale 1ns / 1ps
package plu_pkg;

   localparam int NumStages  = 12;
   localparam int DivFirst   = 1;
   localparam int DivLast    = 8;
   localparam int RatioStage = 9;
   localparam int ProdStage  = 10;
   localparam int FinalStage = 11;

   localparam int ReqBits = 344;
   localparam int RspBits = 352;

   localparam logic [16:0] OneQ16 = 17'd65536;

   localparam logic [7:0] RegGravityX   = 8'd0;
   localparam logic [7:0] RegGravityY   = 8'd1;
   localparam logic [7:0] RegGravityZ   = 8'd2;
   localparam logic [7:0] RegColorStart = 8'd3;
   localparam logic [7:0] RegColorEnd   = 8'd4;
   localparam logic [7:0] RegSizeStart  = 8'd5;
   localparam logic [7:0] RegSizeEnd    = 8'd6;
   localparam logic [7:0] RegAnimSpeed  = 8'd7;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic [31:0]      spin;
      logic [31:0]      rate;
      logic [20:0]      dt;
      logic [30:0]      total;
      logic [31:0]      life_new;
      logic             alive;
      logic             div_skip;
      logic [30:0]      rem;
      logic [15:0]      quo;
      logic [2:0][53:0] mul_v;
      logic [53:0]      mul_s;
      logic [2:0][31:0] vel_new;
      logic [2:0][31:0] pos_new;
      logic [31:0]      spin_new;
      logic [16:0]      ratio;
      logic [3:0][24:0] csum;
      logic [50:0]      size_p;
      logic [47:0]      anim_p;
      logic [31:0]      color;
      logic [31:0]      size;
      logic [30:0]      anim;
   } item_type;

   // floor((p + 0.5) / 1.0) in q16.16
   function automatic logic signed [47:0] round_q16(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + 64'sd32768;
      return $signed(t[63:16]);
   endfunction

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > 64'sd2147483647) r = 32'h7fff_ffff;
      else if (v < -64'sd2147483648) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

FILE: src/particle_life_update_core.sv
// top level: pipelined particle lifetime, color/size blend and euler motion step
`timescale 1ns / 1ps
// Takes one particle request per cycle while req_tready is high, and passes its updated
// record through the pipe registers and then the output register. The depth is set by the
// age-ratio divider, life/total, which resolves two quotient bits per stage over eight
// stages; the motion multiplies run beside it and the blend follows it. A two-entry output
// buffer lets the pipe keep accepting while a finished result waits. The user must write
// registers over the csr port only while no request is in flight; the block does not enforce it.
module particle_life_update_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, life_left, life_total, spin_angle,
   // spin_rate, step_time, zero fill
   input  logic [plu_pkg::ReqBits-1:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z, new_life_left,
   // new_spin_angle, color_now, size_now, anim_time, zero fill
   output logic [plu_pkg::RspBits-1:0] rsp_tdata,
   // alive
   output logic         rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import plu_pkg::*;

   logic [31:0] grav_ff [3];
   logic [31:0] color_start_ff, color_end_ff, size_start_ff, size_end_ff;
   logic [30:0] anim_speed_ff;

   item_type pipe_ff [NumStages];
   item_type pipe_in [NumStages];
   logic [NumStages-1:0] valid_ff;
   logic en;

   logic [RspBits:0] out_ff, skid_ff, out_in;
   logic out_valid_ff, skid_valid_ff, take, push;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff[0]     <= 32'd0;
         grav_ff[1]     <= 32'hffff_0000;
         grav_ff[2]     <= 32'd0;
         color_start_ff <= 32'hffff_ffff;
         color_end_ff   <= 32'hffff_ffff;
         size_start_ff  <= 32'd32768;
         size_end_ff    <= 32'd0;
         anim_speed_ff  <= 31'd65536;
      end else if (csr_valid) begin
         case (csr_index)
            RegGravityX:   grav_ff[0]     <= csr_data;
            RegGravityY:   grav_ff[1]     <= csr_data;
            RegGravityZ:   grav_ff[2]     <= csr_data;
            RegColorStart: color_start_ff <= csr_data;
            RegColorEnd:   color_end_ff   <= csr_data;
            RegSizeStart:  size_start_ff  <= csr_data;
            RegSizeEnd:    size_end_ff    <= csr_data;
            RegAnimSpeed:  anim_speed_ff  <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   assign en = !skid_valid_ff;
   assign req_tready = en;

   always_comb begin
      item_type it;
      logic signed [63:0] life_d;
      logic [31:0] life_sat;
      logic [31:0] rem2;
      logic [7:0] cs, ce;
      it = '0;
      life_d = '0;
      life_sat = '0;
      rem2 = '0;
      cs = '0;
      ce = '0;
      // entry stage: life decrement and divider setup
      for (int i = 0; i < 3; i++) begin
         it.pos[i] = req_tdata[32*i +: 32];
         it.vel[i] = req_tdata[96 + 32*i +: 32];
      end
      it.total = req_tdata[254:224];
      it.spin  = req_tdata[286:255];
      it.rate  = req_tdata[318:287];
      it.dt    = req_tdata[339:319];
      life_d   = 64'($signed(req_tdata[223:192])) - 64'({1'b0, req_tdata[339:319]});
      life_sat = sat32(life_d);
      it.life_new = life_sat;
      it.alive    = !life_sat[31] && (life_sat != 32'd0);
      it.div_skip = !it.alive || (it.total == 31'd0) || (life_sat >= {1'b0, it.total});
      it.rem      = life_sat[30:0];
      pipe_in[0]  = it;

      for (int k = 1; k < NumStages; k++) begin
         it = pipe_ff[k-1];
         if (k >= DivFirst && k <= DivLast) begin
            for (int b = 0; b < 2; b++) begin
               rem2 = {it.rem, 1'b0};
               if (rem2 >= {1'b0, it.total}) begin
                  it.rem = 31'(rem2 - {1'b0, it.total});
                  it.quo = {it.quo[14:0], 1'b1};
               end else begin
                  it.rem = rem2[30:0];
                  it.quo = {it.quo[14:0], 1'b0};
               end
            end
         end
         if (k == 1) begin
            for (int i = 0; i < 3; i++)
               it.mul_v[i] = 54'($signed(grav_ff[i]) * $signed({1'b0, it.dt}));
            it.mul_s = 54'($signed(it.rate) * $signed({1'b0, it.dt}));
         end
         if (k == 2) begin
            for (int i = 0; i < 3; i++)
               it.vel_new[i] = sat32(64'($signed(it.vel[i]))
                                     + 64'(round_q16(64'($signed(it.mul_v[i])))));
            it.spin_new = sat32(64'($signed(it.spin))
                                + 64'(round_q16(64'($signed(it.mul_s)))));
         end
         if (k == 3) begin
            for (int i = 0; i < 3; i++)
               it.mul_v[i] = 54'($signed(it.vel_new[i]) * $signed({1'b0, it.dt}));
         end
         if (k == 4) begin
            for (int i = 0; i < 3; i++)
               it.pos_new[i] = sat32(64'($signed(it.pos[i]))
                                     + 64'(round_q16(64'($signed(it.mul_v[i])))));
         end
         if (k == RatioStage) begin
            // zero total gives a full ratio; otherwise a dead particle or life at or above total gives none
            if (it.div_skip) it.ratio = (it.total == 31'd0) ? OneQ16 : 17'd0;
            else it.ratio = OneQ16 - {1'b0, it.quo};
         end
         if (k == ProdStage) begin
            for (int j = 0; j < 4; j++) begin
               cs = color_start_ff[8*j +: 8];
               ce = color_end_ff[8*j +: 8];
               it.csum[j] = 25'(25'(cs) * 25'(OneQ16 - it.ratio)) + 25'(25'(ce) * 25'(it.ratio));
            end
            // 33-bit span times 18-bit ratio
            it.size_p = 51'($signed(33'($signed(size_end_ff)) - 33'($signed(size_start_ff)))
                            * $signed({1'b0, it.ratio}));
            it.anim_p = 48'(48'(it.ratio) * 48'(anim_speed_ff));
         end
         if (k == FinalStage) begin
            if (it.alive) begin
               for (int j = 0; j < 4; j++)
                  it.color[8*j +: 8] = 8'((it.csum[j] + 25'd32768) >> 16);
               it.size = sat32(64'($signed(size_start_ff))
                               + 64'(round_q16(64'($signed(it.size_p)))));
               it.anim = 31'((it.anim_p + 48'd32768) >> 16);
            end else begin
               it.pos_new  = it.pos;
               it.vel_new  = it.vel;
               it.spin_new = it.spin;
               it.color    = '0;
               it.size     = '0;
               it.anim     = '0;
            end
         end
         pipe_in[k] = it;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NumStages-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NumStages; k++) pipe_ff[k] <= pipe_in[k];
      end
   end

   always_comb begin
      item_type r;
      r = pipe_ff[NumStages-1];
      out_in = {r.alive, 1'b0, r.anim, r.size, r.color, r.spin_new, r.life_new,
                r.vel_new[2], r.vel_new[1], r.vel_new[0],
                r.pos_new[2], r.pos_new[1], r.pos_new[0]};
   end

   assign take = out_valid_ff && rsp_tready;
   assign push = en && valid_ff[NumStages-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || take) out_valid_ff <= 1'b1;
         else skid_valid_ff <= 1'b1;
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) out_ff <= skid_ff;
      end else if (push) begin
         if (!out_valid_ff || take) out_ff <= out_in;
         else skid_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff[RspBits-1:0];
   assign rsp_tuser  = out_ff[RspBits];

   // buffer entry only fills behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff) else $error("skid full with empty output");

   // a request leaving the pipe is never dropped
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      push |=> out_valid_ff) else $error("result lost at pipe exit");

   // dead particles carry no blend results
   a_dead_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff[RspBits]) |-> (out_ff[350:256] == '0))
      else $error("dead particle with nonzero blend fields");

   // the pipe holds while the buffer is full
   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> $stable(valid_ff) || !$past(skid_valid_ff))
      else $error("pipe moved while stalled");

endmodule
